// ===== rtl/derm_pkg.sv =====
// Shared types and constants for the dual-edge chopper RPM meter.
package derm_pkg;

  // Event kinds carried on the input stream.
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_RISE  = 2'd2,
    OP_FALL  = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic CFG_OPENINGS = 1'b0;
  localparam logic CFG_AVERAGE  = 1'b1;

  // Field widths fixed by the stream format.
  localparam int TS_W     = 32;
  localparam int FREQ_W   = 54;
  localparam int CFG_W    = 8;
  localparam int CNT_W    = 16;
  localparam int OUT_DATA_W = 88;

  // Arithmetic constants.
  localparam int US_PER_S  = 1000000;
  localparam int MAX_SCALE = 255;
  // Width of (up to 255) * 10^6, which stays below 2^28.
  localparam int SCALE_W   = 28;

  // Default parameter values.
  localparam int TIME_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== rtl/dual_edge_rpm_meter.sv =====
// Top level of the dual-edge chopper RPM meter: event handling, sequencer and result register.
//
//  Channel  Signals                     Contents
//  cfg      cfg_we/addr/wdata           0 openings, 1 average_revs
//  s        s_tvalid/tready/tdata/tuser timestamp_us in tdata, operation in tuser
//  m        m_tvalid/tready/tdata/tuser time, frequency, pair flag; channel in tuser
//
// Start, stop, ignored edges, reference edges and counted edges without
// averaging that close nothing are handled in the idle state. With averaging,
// a counted edge first runs CNT_W divider steps for the count modulo and
// returns to idle when it closes nothing. A closing edge then runs NUM_W steps
// (28 + FRAC_BITS) of the same restoring divider; a zero interval skips the
// quotient. The input is not ready until the result has entered the output
// register, so a stalled receiver holds the input off while a result waits
// there. rst clears all control state synchronously.
module dual_edge_rpm_meter #(
  parameter int TIME_WIDTH = derm_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = derm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [derm_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [derm_pkg::TS_W-1:0]        s_tdata,  // [31:0] timestamp_us
  input  logic [1:0]                       s_tuser,  // [1:0] operation
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [derm_pkg::OUT_DATA_W-1:0]  m_tdata,  // [31:0] measure_time_us,
                                                     // [85:32] freq_q16,
                                                     // [86] pair_complete, [87] zero
  output logic [0:0]                       m_tuser   // [0] channel
);

  import derm_pkg::*;

  localparam int NUM_W  = SCALE_W + FRAC_BITS;
  localparam int DEN_W  = TIME_WIDTH + CFG_W;
  localparam int STEP_W = $clog2(NUM_W + 1);
  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(MAX_SCALE * US_PER_S) << FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MOD   = 5'b00010,
    S_CLOSE = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [CFG_W-1:0] openings;
  logic [CFG_W-1:0] average_revs;

  // Measurement state.
  logic                  measuring;
  logic                  skip_rise;
  logic [TIME_WIDTH-1:0] ref_time [2];
  logic [1:0]            ref_valid;
  logic [CNT_W-1:0]      edge_count [2];
  logic [1:0]            fresh;

  // Item being worked on.
  logic                  cur_ch;
  logic [TIME_WIDTH-1:0] cur_ts;
  logic [TIME_WIDTH-1:0] interval;
  logic [FREQ_W-1:0]     freq;
  logic                  pair;

  // Output register.
  logic                  out_ch;
  logic [TS_W-1:0]       out_time;
  logic [FREQ_W-1:0]     out_freq;
  logic                  out_pair;

  // Decode of the incoming item.
  op_t                   op;
  logic                  in_xfer;
  logic                  is_edge;
  logic                  ch;
  logic [TIME_WIDTH-1:0] ts_w;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CFG_W-1:0]      slots;
  logic [CNT_W-1:0]      period;
  logic [SCALE_W-1:0]    scale;
  logic [1:0]            fresh_now;

  // Divider interface.
  logic              div_start;
  logic [STEP_W-1:0] div_steps;
  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  always_comb begin
    op        = op_t'(s_tuser);
    is_edge   = (op == OP_RISE) || (op == OP_FALL);
    ch        = (op == OP_FALL);
    ts_w      = TIME_WIDTH'(s_tdata);
    cnt_inc   = edge_count[ch] + CNT_W'(1);
    slots     = (openings == '0) ? CFG_W'(1) : openings;
    period    = CNT_W'(average_revs) * CNT_W'(slots);
    scale     = SCALE_W'(((average_revs == '0) ? CFG_W'(1) : average_revs) * US_PER_S);
    fresh_now = fresh;
    fresh_now[cur_ch] = 1'b1;
  end

  // An averaging edge needs the count modulo; a closing edge needs the quotient.
  always_comb begin
    div_start = 1'b0;
    if (state == S_IDLE) begin
      div_steps = STEP_W'(CNT_W);
      div_num   = {cnt_inc, {(NUM_W - CNT_W){1'b0}}};
      div_den   = DEN_W'(period);
      if (in_xfer && is_edge && measuring && !(op == OP_RISE && skip_rise) &&
          ref_valid[ch] && average_revs != '0 && cnt_inc != '0) begin
        div_start = 1'b1;
      end
    end else begin
      div_steps = STEP_W'(NUM_W);
      div_num   = NUM_W'(scale) << FRAC_BITS;
      div_den   = (average_revs == '0) ? DEN_W'(slots) * DEN_W'(interval)
                                       : DEN_W'(interval);
      if (state == S_CLOSE && interval != '0) begin
        div_start = 1'b1;
      end
    end
  end

  derm_divider #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .STEP_W (STEP_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .steps     (div_steps),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      openings     <= CFG_W'(1);
      average_revs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OPENINGS: openings     <= cfg_wdata;
        CFG_AVERAGE:  average_revs <= cfg_wdata;
        default:      openings     <= openings;
      endcase
    end
  end

  // Sequencer and measurement state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      measuring  <= 1'b0;
      skip_rise  <= 1'b0;
      ref_valid  <= '0;
      fresh      <= '0;
      ref_time   <= '{default: '0};
      edge_count <= '{default: '0};
      m_tvalid   <= 1'b0;
    end else begin
      // Result valid: set when a result is loaded, cleared when it is taken.
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cur_ch   <= ch;
            cur_ts   <= ts_w;
            interval <= ts_w - ref_time[ch];
            if (op == OP_START) begin
              measuring  <= 1'b1;
              skip_rise  <= 1'b1;
              ref_valid  <= '0;
              ref_time   <= '{default: '0};
              edge_count <= '{default: '0};
            end else if (op == OP_STOP) begin
              measuring <= 1'b0;
            end else if (measuring) begin
              if (op == OP_RISE && skip_rise) begin
                skip_rise <= 1'b0;
              end else if (!ref_valid[ch]) begin
                ref_time[ch]  <= ts_w;
                ref_valid[ch] <= 1'b1;
              end else begin
                edge_count[ch] <= cnt_inc;
                if (average_revs == '0) begin
                  if (cnt_inc == CNT_W'(1)) begin
                    state <= S_CLOSE;
                  end
                end else if (cnt_inc != '0) begin
                  state <= S_MOD;
                end
              end
            end
          end
        end
        S_MOD: begin
          if (div_done) begin
            state <= (div_rem == '0) ? S_CLOSE : S_IDLE;
          end
        end
        S_CLOSE: begin
          ref_time[cur_ch]   <= cur_ts;
          edge_count[cur_ch] <= '0;
          if (fresh_now == 2'b11) begin
            fresh <= '0;
            pair  <= 1'b1;
          end else begin
            fresh <= fresh_now;
            pair  <= 1'b0;
          end
          if (interval == '0) begin
            freq  <= FREQ_MAX;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            freq  <= FREQ_W'(div_quo);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand over to the output register once the previous result has gone out.
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      out_ch   <= cur_ch;
      out_time <= TS_W'(cur_ts);
      out_freq <= freq;
      out_pair <= pair;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - TS_W - FREQ_W - 1){1'b0}}, out_pair, out_freq, out_time};
  assign m_tuser = out_ch;

endmodule

// ===== rtl/derm_divider.sv =====
// Bit-serial restoring divider shared for the count modulo and the frequency quotient.
module derm_divider #(
  parameter int NUM_W  = 44,
  parameter int DEN_W  = 40,
  parameter int STEP_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] steps,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [NUM_W-1:0]  quotient,
  output logic [DEN_W-1:0]  remainder
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den;
  logic [DEN_W+1:0]  diff;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // One trial subtraction per cycle on the shifted partial remainder.
  always_comb begin
    diff     = {1'b0, rem, quo[NUM_W-1]} - {2'b00, den};
    ge       = ~diff[DEN_W+1];
    rem_next = ge ? diff[DEN_W-1:0] : {rem[DEN_W-2:0], quo[NUM_W-1]};
  end

  // Control: load on start, then shift out one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/derm_checker.sv =====
// Port-level assertions for the dual-edge chopper RPM meter, bound to the top level.
module derm_checker #(
  parameter int FRAC_BITS = derm_pkg::FRAC_BITS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [1:0]                      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [derm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                      m_tuser
);

  import derm_pkg::*;

  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(MAX_SCALE * US_PER_S) << FRAC_BITS;

  // A result that is held back stays put until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Start and stop never occupy the sequencer.
  a_ctl_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_START || s_tuser == OP_STOP) |=> s_tready)
    else $error("not ready after start or stop");

  // A new result only appears out of a busy sequencer.
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without work");

  // The frequency never exceeds the saturation value.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[TS_W +: FREQ_W] <= FREQ_MAX)
    else $error("frequency above saturation");

endmodule

bind dual_edge_rpm_meter derm_checker #(.FRAC_BITS(FRAC_BITS)) u_derm_checker (.*);

// ===== tb/sv/dual_edge_rpm_meter_tb.sv =====
// Self-checking testbench for the dual-edge chopper RPM meter.
module dual_edge_rpm_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import derm_pkg::*;

  // One frequency reading as it leaves the meter.
  typedef struct packed {
    bit        ch;
    bit [31:0] at_us;
    bit [53:0] freq;
    bit        pair;
  } reading_t;

  // How a directed row is checked.
  typedef enum bit [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_READING
  } row_kind_t;

  typedef struct packed {
    op_t       op;
    bit [31:0] ts;
    row_kind_t kind;
    bit        ch;
    bit [53:0] freq;
    bit        pair;
  } dir_row_t;

  // Register setting, traffic shape and length of one random phase.
  typedef struct packed {
    int open_n;
    int avg_n;
    int tx_idle;
    int rx_stall;
    int items;
    bit hold;
    bit restarts;
  } phase_t;

  localparam bit [63:0] ONE_REV_Q16 = 64'(US_PER_S) << FRAC_BITS_DEF;
  localparam bit [63:0] FREQ_SAT    = 64'(MAX_SCALE * US_PER_S) << FRAC_BITS_DEF;
  localparam bit [53:0] KHZ_Q16     = 54'd65536000;     // 1 kHz
  localparam bit [53:0] MHZ_Q16     = 54'd65536000000;  // 1 MHz

  localparam int DRAIN_CYCLES = 80;
  localparam int TAIL_CYCLES  = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  // Directed events at the reset setting: one slot, no averaging.
  localparam int DIR_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{OP_RISE,  32'd5,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd7,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_STOP,  32'd0,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_START, 32'd0,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd100,        ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd200,        ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd200,        ROW_READING, 1'b0, FREQ_SAT[53:0],  1'b0},
    '{OP_FALL,  32'd300,        ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd1300,       ROW_READING, 1'b1, KHZ_Q16,         1'b1},
    '{OP_RISE,  32'd1200,       ROW_READING, 1'b0, KHZ_Q16,         1'b0},
    '{OP_RISE,  32'd1201,       ROW_READING, 1'b0, MHZ_Q16,         1'b0},
    '{OP_FALL,  32'hFFFF_FFFF,  ROW_PREDICT, 1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd0,          ROW_PREDICT, 1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'hFFFF_FFFF,  ROW_PREDICT, 1'b0, 54'd0,           1'b0},
    '{OP_STOP,  32'd1,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd5,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd6,          ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_START, 32'hFFFF_FFFF,  ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd10,         ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd20,         ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd30,         ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_START, 32'd40,         ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd50,         ROW_QUIET,   1'b0, 54'd0,           1'b0},
    '{OP_FALL,  32'd49,         ROW_PREDICT, 1'b0, 54'd0,           1'b0},
    '{OP_RISE,  32'd60,         ROW_QUIET,   1'b0, 54'd0,           1'b0}
  };

  // Random phases: openings, averaging, sender idle %, receiver stall %, events.
  localparam int PHASE_N = 8;
  localparam phase_t PHASES [PHASE_N] = '{
    '{1,   0,   0,  0,  200, 1'b0, 1'b1},
    '{255, 0,   66, 0,  200, 1'b0, 1'b1},
    '{4,   1,   0,  66, 200, 1'b0, 1'b1},
    '{2,   3,   8,  8,  200, 1'b0, 1'b1},
    '{255, 255, 0,  0,  50,  1'b0, 1'b0},
    '{1,   255, 66, 66, 550, 1'b0, 1'b0},
    '{3,   2,   0,  0,  200, 1'b1, 1'b1},
    '{1,   1,   8,  8,  100, 1'b0, 1'b1}
  };

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_addr  = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [TS_W-1:0]       s_tdata   = '0;
  logic [1:0]            s_tuser   = OP_STOP;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;

  dual_edge_rpm_meter u_top (.*);

  always #5 clk = ~clk;

  // Predictor state and its copy of the registers.
  bit        run_on;
  bit        skip_rise;
  bit [31:0] ref_us [2];
  bit        ref_ok [2];
  bit [15:0] edges_seen [2];
  bit        fresh [2];
  bit [7:0]  slots_cfg = 8'd1;
  bit [7:0]  revs_cfg  = 8'd0;

  // Traffic shaping shared between the stimulus and the receiver.
  int        tx_idle_pct;
  int        rx_stall_pct;
  int        hold_seq;
  bit        restarts_on = 1'b1;
  bit [31:0] chop_now;
  op_t       last_edge = OP_FALL;

  reading_t  freq_expected [$];
  int        fails;
  int        events_sent;
  int        readings_seen;
  int        pairs_seen;
  int        sat_seen;

  // Revolution frequency in Q.16 Hz over one closed interval.
  function automatic bit [53:0] rev_freq(input bit [31:0] span, input int unsigned slots);
    bit [63:0] num;
    if (span == 0)
      return FREQ_SAT[53:0];
    if (revs_cfg == 0)
      num = (ONE_REV_Q16 / slots) / span;
    else
      num = ((64'(revs_cfg) * US_PER_S) << FRAC_BITS_DEF) / span;
    return num[53:0];
  endfunction

  // Advances the meter state for one event; returns 1 when a reading comes out.
  function automatic bit tacho_predict(input op_t op, input bit [31:0] ts,
                                       output reading_t rd);
    int          ch;
    int unsigned slots;
    int unsigned period;
    bit          close;
    rd = '0;
    case (op)
      OP_START: begin
        run_on    = 1'b1;
        skip_rise = 1'b1;
        for (int i = 0; i < 2; i++) begin
          ref_us[i]     = '0;
          ref_ok[i]     = 1'b0;
          edges_seen[i] = '0;
        end
        return 1'b0;
      end
      OP_STOP: begin
        run_on = 1'b0;
        return 1'b0;
      end
      default: begin
        if (!run_on)
          return 1'b0;
        if (op == OP_RISE && skip_rise) begin
          skip_rise = 1'b0;
          return 1'b0;
        end
      end
    endcase

    ch = (op == OP_FALL) ? 1 : 0;
    if (!ref_ok[ch]) begin
      ref_us[ch] = ts;
      ref_ok[ch] = 1'b1;
      return 1'b0;
    end
    edges_seen[ch] = edges_seen[ch] + 16'd1;
    slots  = (slots_cfg == 0) ? 1 : slots_cfg;
    period = revs_cfg * slots;
    if (revs_cfg == 0)
      close = (edges_seen[ch] == 16'd1);
    else
      close = (edges_seen[ch] != 0) && (edges_seen[ch] % period == 0);
    if (!close)
      return 1'b0;

    rd.ch          = ch[0];
    rd.at_us       = ts;
    rd.freq        = rev_freq(ts - ref_us[ch], slots);
    ref_us[ch]     = ts;
    edges_seen[ch] = '0;
    fresh[ch]      = 1'b1;
    rd.pair        = fresh[0] && fresh[1];
    if (rd.pair) begin
      fresh[0] = 1'b0;
      fresh[1] = 1'b0;
    end
    return 1'b1;
  endfunction

  // Next chopper event: mostly alternating edges on a running clock, some noise.
  function automatic void chopper_event(output op_t op, output bit [31:0] ts);
    int unsigned roll;
    bit [31:0]   step;
    roll = $urandom_range(99);
    if (!run_on && (roll < 80 || !restarts_on))
      op = OP_START;
    else if (restarts_on && roll < 2)
      op = OP_START;
    else if (restarts_on && roll < 4)
      op = OP_STOP;
    else if (roll < 12)
      op = restarts_on ? op_t'($urandom_range(3)) : op_t'($urandom_range(3, 2));
    else
      op = (last_edge == OP_RISE) ? OP_FALL : OP_RISE;
    if (op == OP_RISE || op == OP_FALL)
      last_edge = op;

    roll = $urandom_range(99);
    if (roll < 5)
      step = '0;
    else if (roll < 10)
      step = $urandom;
    else if (roll < 20)
      step = $urandom_range(3);
    else
      step = $urandom_range(20000, 1);
    chop_now = chop_now + step;
    ts = ($urandom_range(99) < 5) ? 32'($urandom) : chop_now;
  endfunction

  task automatic report_fail(input string why, input reading_t want, input reading_t got);
    if (fails < MAX_REPORTS)
      $display("%0t %s: expected ch %0d t %0d f %0d pair %0d, got ch %0d t %0d f %0d pair %0d",
               $time, why, want.ch, want.at_us, want.freq, want.pair,
               got.ch, got.at_us, got.freq, got.pair);
    fails++;
  endtask

  // Offers one event after a random idle stretch and waits for its transfer.
  task automatic send_event(input op_t op, input bit [31:0] ts);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ts;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    events_sent++;
  endtask

  // Waits for every pending reading, then for a divider pass that closes nothing.
  task automatic wait_drained(input int settle);
    while (freq_expected.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes both registers on consecutive edges and mirrors them in the predictor.
  task automatic set_tacho_cfg(input int open_n, input int avg_n);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_OPENINGS;
    cfg_wdata <= CFG_W'(open_n);
    @(posedge clk);
    cfg_addr  <= CFG_AVERAGE;
    cfg_wdata <= CFG_W'(avg_n);
    @(posedge clk);
    cfg_we    <= 1'b0;
    slots_cfg = 8'(open_n);
    revs_cfg  = 8'(avg_n);
  endtask

  // Receiver: random stalls, or one long hold-off when the stimulus asks.
  initial begin : rx_side
    int seen_hold;
    seen_hold = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Compare each output transfer with the oldest pending reading.
  always @(posedge clk) begin : rx_check
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ch    = m_tuser[0];
      got.at_us = m_tdata[31:0];
      got.freq  = m_tdata[85:32];
      got.pair  = m_tdata[86];
      readings_seen++;
      if (got.pair)
        pairs_seen++;
      if (got.freq == FREQ_SAT[53:0])
        sat_seen++;
      if (freq_expected.size() == 0) begin
        report_fail("unexpected reading", '0, got);
      end else begin
        want = freq_expected.pop_front();
        if (got != want)
          report_fail("reading mismatch", want, got);
      end
    end
  end

  // Ends the run when nothing has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Stimulus: directed rows, then random phases across register settings.
  initial begin : stimulus
    reading_t rd;
    op_t      op;
    bit [31:0] ts;
    bit       made;
    bit       ignored;
    int       sent;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset setting.
    for (int i = 0; i < DIR_N; i++) begin
      send_event(DIR_ROWS[i].op, DIR_ROWS[i].ts);
      made = tacho_predict(DIR_ROWS[i].op, DIR_ROWS[i].ts, rd);
      case (DIR_ROWS[i].kind)
        ROW_READING: freq_expected.push_back('{DIR_ROWS[i].ch, DIR_ROWS[i].ts,
                                               DIR_ROWS[i].freq, DIR_ROWS[i].pair});
        ROW_PREDICT: if (made) freq_expected.push_back(rd);
        default: ;
      endcase
    end

    // Random phases; registers change only once the meter has gone quiet.
    for (int p = 0; p < PHASE_N; p++) begin
      s_tvalid <= 1'b0;
      wait_drained(DRAIN_CYCLES);
      set_tacho_cfg(PHASES[p].open_n, PHASES[p].avg_n);
      tx_idle_pct  = PHASES[p].tx_idle;
      rx_stall_pct = PHASES[p].rx_stall;
      restarts_on  = PHASES[p].restarts;
      chop_now     = $urandom;
      if (PHASES[p].hold)
        hold_seq++;
      sent = 0;
      while (sent < PHASES[p].items) begin
        chopper_event(op, ts);
        ignored = (op == OP_RISE || op == OP_FALL) && !run_on;
        send_event(op, ts);
        if (tacho_predict(op, ts, rd))
          freq_expected.push_back(rd);
        if (!ignored)
          sent++;
      end
    end

    s_tvalid <= 1'b0;
    wait_drained(TAIL_CYCLES);
    if (freq_expected.size() != 0) begin
      $display("%0d readings never arrived", freq_expected.size());
      fails += freq_expected.size();
    end

    $display("Covered %0d events over %0d register settings, idle and stalled traffic,",
             events_sent, PHASE_N + 1);
    $display("and %0d readings checked (%0d completing a pair, %0d saturated); %0d errors.",
             readings_seen, pairs_seen, sat_seen, fails);
    if (fails == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== dual_edge_rpm_meter.f =====
rtl/derm_pkg.sv
rtl/derm_divider.sv
rtl/dual_edge_rpm_meter.sv
rtl/derm_checker.sv
tb/sv/dual_edge_rpm_meter_tb.sv
